// ===== sv/dtcm_pkg.sv =====
// dtcm_pkg: shared types and codes for the trouble code store
// used by dtcm_ctrl, dtcm_datapath and dtc_event_memory; no dependencies
package dtcm_pkg;

  localparam int CODE_W  = 24;
  localparam int STAT_W  = 8;
  localparam int OCC_W   = 32;
  localparam int COUNT_W = 5;

  localparam logic [OCC_W-1:0] OCC_MAX = '1;

  // input kinds carried on tuser
  localparam logic ACT_REPORT = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // register index, taken from paddr bit 2
  localparam logic REG_TEST_FAILED = 1'b0;
  localparam logic REG_CONFIRMED   = 1'b1;

  localparam logic [STAT_W-1:0] TEST_FAILED_RESET = 8'h01;
  localparam logic [STAT_W-1:0] CONFIRMED_RESET   = 8'h08;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occ;
  } entry_t;

  // packed so that lamp_on sits in bit 0
  typedef struct packed {
    logic               dropped;
    logic               was_new;
    logic [OCC_W-1:0]   entry_occurrences;
    logic [STAT_W-1:0]  entry_status;
    logic [COUNT_W-1:0] code_count;
    logic               lamp_on;
  } result_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/dtcm_ctrl.sv =====
// dtcm_ctrl: sequencer for accept, table scan and commit
// depends on dtcm_pkg for the command and status structs
module dtcm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dtcm_pkg::sts_t sts,
  output dtcm_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (sts.scan_done) state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      S_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== sv/dtcm_datapath.sv =====
// dtcm_datapath: entry memory, scan counter, match and lamp logic, result register
// depends on dtcm_pkg; driven by dtcm_ctrl commands
module dtcm_datapath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dtcm_pkg::cmd_t                cmd,
  output dtcm_pkg::sts_t                sts,
  input  logic                          in_action,
  input  logic [dtcm_pkg::CODE_W-1:0]   in_code,
  input  logic [dtcm_pkg::STAT_W-1:0]   in_status,
  input  logic [dtcm_pkg::STAT_W-1:0]   test_failed_bit,
  input  logic [dtcm_pkg::STAT_W-1:0]   confirmed_bit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dtcm_pkg::result_t             result
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  dtcm_pkg::entry_t mem [TABLE_DEPTH];

  // item being worked on
  logic                        item_action;
  logic [dtcm_pkg::CODE_W-1:0] item_code;
  logic [dtcm_pkg::STAT_W-1:0] item_status;

  // scan state
  logic [CNT_W-1:0]   entries_used;
  logic [CNT_W-1:0]   issue_cnt;
  logic [CNT_W-1:0]   scan_limit;
  logic               pend;
  logic [IDX_W-1:0]   pend_idx;
  logic               found;
  logic               lamp_acc;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_idx;
  dtcm_pkg::entry_t   rd_data;
  dtcm_pkg::entry_t   hit;
  logic [IDX_W-1:0]   hit_idx;

  // commit
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  dtcm_pkg::entry_t   wr_entry;
  logic [CNT_W-1:0]   entries_used_next;
  dtcm_pkg::result_t  result_next;
  logic [CNT_W+4:0]   count_wide;
  logic               full;
  logic               tf_hit;
  logic [dtcm_pkg::STAT_W-1:0] upd_status;
  logic [dtcm_pkg::OCC_W-1:0]  upd_occ;

  assign scan_limit = (item_action == dtcm_pkg::ACT_CLEAR) ? '0 : entries_used;
  assign rd_en      = cmd.scan_en && (issue_cnt < scan_limit);
  assign rd_idx     = issue_cnt[IDX_W-1:0];

  assign sts.scan_done = (issue_cnt == scan_limit) && !pend;
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_entry;
    if (rd_en) rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
      lamp_acc  <= 1'b0;
    end else if (cmd.load) begin
      issue_cnt <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
      lamp_acc  <= 1'b0;
    end else if (cmd.scan_en) begin
      pend <= rd_en;
      if (rd_en) issue_cnt <= issue_cnt + CNT_W'(1);
      if (pend) begin
        // codes are unique in the table, so the matched slot is left out of the
        // lamp sum and added back with its updated status at commit
        if (rd_data.code == item_code) begin
          found <= 1'b1;
        end else if ((rd_data.status & confirmed_bit) != '0) begin
          lamp_acc <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_action <= in_action;
      item_code   <= in_code;
      item_status <= in_status;
    end
    if (rd_en) pend_idx <= rd_idx;
    if (cmd.scan_en && pend && (rd_data.code == item_code)) begin
      hit     <= rd_data;
      hit_idx <= pend_idx;
    end
  end

  assign full   = (entries_used == CNT_W'(TABLE_DEPTH));
  assign tf_hit = (item_status & test_failed_bit) != '0;

  always_comb begin
    upd_status = hit.status | item_status;
    upd_occ    = hit.occ;
    if (tf_hit) begin
      if (hit.occ != dtcm_pkg::OCC_MAX) upd_occ = hit.occ + 32'd1;
    end else begin
      upd_status = upd_status & ~test_failed_bit;
    end
  end

  always_comb begin
    wr_en             = 1'b0;
    wr_idx            = hit_idx;
    wr_entry          = hit;
    entries_used_next = entries_used;
    result_next       = '0;
    if (item_action == dtcm_pkg::ACT_CLEAR) begin
      entries_used_next = '0;
    end else if (found) begin
      wr_en                         = cmd.commit;
      wr_entry.status               = upd_status;
      wr_entry.occ                  = upd_occ;
      result_next.entry_status      = upd_status;
      result_next.entry_occurrences = upd_occ;
      result_next.lamp_on           = lamp_acc || ((upd_status & confirmed_bit) != '0);
    end else if (!full) begin
      wr_en                         = cmd.commit;
      wr_idx                        = entries_used[IDX_W-1:0];
      wr_entry.code                 = item_code;
      wr_entry.status               = item_status;
      wr_entry.occ                  = 32'd1;
      entries_used_next             = entries_used + CNT_W'(1);
      result_next.entry_status      = item_status;
      result_next.entry_occurrences = 32'd1;
      result_next.was_new           = 1'b1;
      result_next.lamp_on           = lamp_acc || ((item_status & confirmed_bit) != '0);
    end else begin
      result_next.dropped = 1'b1;
      result_next.lamp_on = lamp_acc;
    end
    // low five bits of the count, whatever the table depth
    count_wide             = {5'b0, entries_used_next};
    result_next.code_count = count_wide[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.commit) begin
        entries_used <= entries_used_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) result <= result_next;
  end

  a_new_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && result_next.was_new) |=> entries_used == $past(entries_used) + CNT_W'(1))
    else $error("new entry did not grow the table");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && result_next.dropped) |-> full)
    else $error("report dropped while table had room");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && item_action == dtcm_pkg::ACT_CLEAR) |=> entries_used == '0)
    else $error("clear left entries in the table");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit overwrote a pending result");

endmodule

// ===== sv/dtc_event_memory.sv =====
// dtc_event_memory: diagnostic trouble code store with warning lamp, top level
// holds the configuration registers; instantiates dtcm_ctrl and dtcm_datapath (dtcm_pkg)
//
//  channel   direction  handshake         payload
//  s_*       in         s_tvalid/s_tready tdata {event_status, trouble_code}, tuser action
//  m_*       out        m_tvalid/m_tready tdata {dropped, was_new, occurrences, status,
//                                                code_count, lamp_on}
//  apb       in         psel/penable      reg 0 test_failed_bit, reg 1 confirmed_bit
//
// a report on n >= 1 stored entries makes one read per entry, waits for the read data,
// closes the scan and commits; a clear, or a report on an empty table, makes no read;
// the next word is taken after the commit, once the block is back in idle, so one item
// is finished before the next is taken
// reset is synchronous; the table content is not cleared, only the entry count
// the result waits in an output register; the next word is accepted meanwhile, and
// its commit waits until the output register is free
module dtc_event_memory #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // trouble_code [23:0], event_status [31:24]
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // lamp_on, code_count, entry_status, entry_occurrences,
                                 // was_new, dropped
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [dtcm_pkg::STAT_W-1:0] test_failed_bit;
  logic [dtcm_pkg::STAT_W-1:0] confirmed_bit;
  dtcm_pkg::cmd_t              cmd;
  dtcm_pkg::sts_t              sts;
  dtcm_pkg::result_t           result;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      test_failed_bit <= dtcm_pkg::TEST_FAILED_RESET;
      confirmed_bit   <= dtcm_pkg::CONFIRMED_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        dtcm_pkg::REG_TEST_FAILED: test_failed_bit <= pwdata[7:0];
        dtcm_pkg::REG_CONFIRMED:   confirmed_bit   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dtcm_pkg::REG_TEST_FAILED: prdata = {24'b0, test_failed_bit};
      dtcm_pkg::REG_CONFIRMED:   prdata = {24'b0, confirmed_bit};
      default:                   prdata = '0;
    endcase
  end

  dtcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtcm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (s_tuser),
    .in_code         (s_tdata[23:0]),
    .in_status       (s_tdata[31:24]),
    .test_failed_bit (test_failed_bit),
    .confirmed_bit   (confirmed_bit),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .result          (result)
  );

  assign m_tdata = result;

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for the dtc_event_memory trouble code store
// drives report and clear words with random gaps and stalls, predicts every result
// word internally and compares it field by field; depends on dtcm_pkg and the rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE = DEPTH + 8;

  localparam int CODE_W  = dtcm_pkg::CODE_W;
  localparam int STAT_W  = dtcm_pkg::STAT_W;
  localparam int OCC_W   = dtcm_pkg::OCC_W;
  localparam int COUNT_W = dtcm_pkg::COUNT_W;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // trouble_code [23:0], event_status [31:24]
  logic        s_tuser;   // action
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // lamp_on, code_count, entry_status, entry_occurrences,
                          // was_new, dropped
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dtc_event_memory #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // shadow of the code table and its settings
  logic [CODE_W-1:0] tbl_code [DEPTH];
  logic [STAT_W-1:0] tbl_stat [DEPTH];
  logic [OCC_W-1:0]  tbl_occ  [DEPTH];
  int                n_used;
  logic              lamp;
  logic [STAT_W-1:0] tf_mask;
  logic [STAT_W-1:0] cf_mask;

  dtcm_pkg::result_t pending_results[$];
  int                errors = 0;
  int                words_seen = 0;
  bit                idle_en = 1'b1;
  bit                hold_req = 1'b0;
  logic [CODE_W-1:0] code_pool [24];

  function automatic dtcm_pkg::result_t predict_word(input logic act,
                                                     input logic [CODE_W-1:0] code,
                                                     input logic [STAT_W-1:0] st);
    dtcm_pkg::result_t r;
    int      slot;
    logic    hit;
    r = '0;
    hit = 1'b0;
    slot = 0;
    if (act == dtcm_pkg::ACT_CLEAR) begin
      n_used = 0;
    end else begin
      for (int i = 0; i < n_used; i++) begin
        if (!hit && tbl_code[i] == code) begin
          hit = 1'b1;
          slot = i;
        end
      end
      if (hit) begin
        tbl_stat[slot] = tbl_stat[slot] | st;
        if ((st & tf_mask) != '0) begin
          if (tbl_occ[slot] != dtcm_pkg::OCC_MAX) tbl_occ[slot] = tbl_occ[slot] + 1;
        end else begin
          tbl_stat[slot] = tbl_stat[slot] & ~tf_mask;
        end
        r.entry_status = tbl_stat[slot];
        r.entry_occurrences = tbl_occ[slot];
      end else if (n_used < DEPTH) begin
        tbl_code[n_used] = code;
        tbl_stat[n_used] = st;
        tbl_occ[n_used] = 1;
        n_used++;
        r.entry_status = st;
        r.entry_occurrences = 1;
        r.was_new = 1'b1;
      end else begin
        r.dropped = 1'b1;
      end
    end
    lamp = 1'b0;
    for (int i = 0; i < n_used; i++) begin
      if ((tbl_stat[i] & cf_mask) != '0) lamp = 1'b1;
    end
    r.lamp_on = lamp;
    r.code_count = n_used[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH word %0d %s: got 0x%0h expected 0x%0h", words_seen, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    dtcm_pkg::result_t got;
    dtcm_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = dtcm_pkg::result_t'(m_tdata);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", m_tdata[31:0], 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (got.lamp_on !== want.lamp_on)
          report_mismatch("lamp_on", 32'(got.lamp_on), 32'(want.lamp_on));
        if (got.code_count !== want.code_count)
          report_mismatch("code_count", 32'(got.code_count), 32'(want.code_count));
        if (got.entry_status !== want.entry_status)
          report_mismatch("entry_status", 32'(got.entry_status), 32'(want.entry_status));
        if (got.entry_occurrences !== want.entry_occurrences)
          report_mismatch("entry_occurrences", got.entry_occurrences,
                          want.entry_occurrences);
        if (got.was_new !== want.was_new)
          report_mismatch("was_new", 32'(got.was_new), 32'(want.was_new));
        if (got.dropped !== want.dropped)
          report_mismatch("dropped", 32'(got.dropped), 32'(want.dropped));
      end
      words_seen++;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        hold_req = 1'b0;
        for (int k = 1; k < LONG_HOLD; k++) @(negedge clk);
      end else if (idle_en && !rst && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic act, input logic [CODE_W-1:0] code,
                           input logic [STAT_W-1:0] st);
    int n;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 18);
      repeat (n) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {st, code};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_word(act, code, st));
  endtask

  // let every outstanding word come back, then give the block time to settle
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [STAT_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == dtcm_pkg::REG_TEST_FAILED) tf_mask = val;
    else cf_mask = val;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[STAT_W-1:0] !== val) report_mismatch("register readback", prdata, 32'(val));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_masks(input logic [STAT_W-1:0] tf, input logic [STAT_W-1:0] cf);
    drain();
    write_reg(dtcm_pkg::REG_TEST_FAILED, tf);
    write_reg(dtcm_pkg::REG_CONFIRMED, cf);
  endtask

  task automatic refresh_pool();
    foreach (code_pool[i]) code_pool[i] = CODE_W'($urandom_range(0, 24'hFFFFFF));
  endtask

  // mostly codes from a small pool so entries get hit again, with clears that
  // keep the table moving between empty and full
  task automatic send_random();
    int pick;
    logic [CODE_W-1:0] code;
    pick = $urandom_range(0, 99);
    code = (pick < 75) ? code_pool[$urandom_range(0, 23)]
                       : CODE_W'($urandom_range(0, 24'hFFFFFF));
    if (pick >= 95)
      send_word(dtcm_pkg::ACT_CLEAR, CODE_W'($urandom_range(0, 24'hFFFFFF)),
                STAT_W'($urandom_range(0, 255)));
    else send_word(dtcm_pkg::ACT_REPORT, code, STAT_W'($urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    send_word(dtcm_pkg::ACT_REPORT, 24'h000000, 8'h01);
    send_word(dtcm_pkg::ACT_REPORT, 24'hFFFFFF, 8'hFF);
    send_word(dtcm_pkg::ACT_REPORT, 24'h000000, 8'h01);
    // report without test failed clears that bit in the entry
    send_word(dtcm_pkg::ACT_REPORT, 24'hFFFFFF, 8'h00);
    send_word(dtcm_pkg::ACT_CLEAR, 24'hABCDEF, 8'h5A);
    for (int i = 0; i < DEPTH; i++)
      send_word(dtcm_pkg::ACT_REPORT, CODE_W'(24'h100000 + i), (i == 7) ? 8'h08 : 8'h01);
    // table full: a new code is dropped, a stored one still updates
    send_word(dtcm_pkg::ACT_REPORT, 24'h7FFFFF, 8'h09);
    send_word(dtcm_pkg::ACT_REPORT, 24'h100003, 8'h01);
    send_word(dtcm_pkg::ACT_CLEAR, 24'h000000, 8'h00);
  endtask

  task automatic test_mask_settings();
    logic [STAT_W-1:0] tf_set [5];
    logic [STAT_W-1:0] cf_set [5];
    tf_set = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h00};
    cf_set = '{8'h00, 8'hFF, 8'h01, 8'h08, 8'h00};
    tf_set[4] = STAT_W'($urandom_range(0, 255));
    cf_set[4] = STAT_W'($urandom_range(0, 255));
    for (int s = 0; s < 5; s++) begin
      set_masks(tf_set[s], cf_set[s]);
      refresh_pool();
      repeat (200) send_random();
    end
  endtask

  task automatic test_backpressure();
    drain();
    refresh_pool();
    hold_req = 1'b1;
    repeat (60) send_random();
  endtask

  task automatic test_random_mix();
    set_masks(STAT_W'($urandom_range(0, 255)), STAT_W'($urandom_range(0, 255)));
    for (int b = 0; b < 6; b++) begin
      refresh_pool();
      repeat (100) send_random();
    end
  endtask

  task automatic test_no_idle();
    set_masks(dtcm_pkg::TEST_FAILED_RESET, dtcm_pkg::CONFIRMED_RESET);
    idle_en = 1'b0;
    refresh_pool();
    repeat (200) send_random();
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = dtcm_pkg::ACT_REPORT;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    n_used = 0;
    lamp = 1'b0;
    tf_mask = dtcm_pkg::TEST_FAILED_RESET;
    cf_mask = dtcm_pkg::CONFIRMED_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_mask_settings();
    test_backpressure();
    test_random_mix();
    test_no_idle();

    @(negedge clk);
    s_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("words never returned", pending_results.size(), 0);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
